>>> rtl/fhws_pkg.sv
// Shared types and constants for the flow hash worker steering block.
`default_nettype none
package fhws_pkg;

  localparam int MaxWorkersDefault = 256;
  localparam int HashW             = 32;
  localparam int CfgW              = 9;
  localparam int PosW              = 6;
  localparam int DivCntW           = $clog2(HashW);

  localparam logic [HashW-1:0] MixMult     = 32'h045d9f3b;
  localparam logic [PosW-1:0]  MinFrameLen = 6'd38;
  localparam logic [PosW-1:0]  TypeHiPos   = 6'd12;
  localparam logic [PosW-1:0]  TypeLoPos   = 6'd13;
  localparam logic [PosW-1:0]  IpOffIpv4   = 6'd26;
  localparam logic [PosW-1:0]  IpOffVlan   = 6'd30;
  localparam logic [PosW-1:0]  ProtoBack   = 6'd3;
  localparam logic [PosW-1:0]  FlowBytes   = 6'd12;
  localparam logic [7:0]       TypeIpv4Hi  = 8'h08;
  localparam logic [7:0]       TypeVlanHi  = 8'h81;
  localparam logic [7:0]       ProtoTcp    = 8'd6;
  localparam logic [7:0]       ProtoUdp    = 8'd17;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_IPV4,
    KIND_VLAN
  } kind_t;

  typedef enum logic [2:0] {
    ST_RX,
    ST_LOAD,
    ST_MIX1,
    ST_MIX2,
    ST_FOLD,
    ST_DIV,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic mix1;
    logic mix2;
    logic fold;
    logic div_step;
    logic put;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/flow_hash_worker_steering_core.sv
// Top level of the flow hash worker steering block.
// Bytes are taken one per cycle while in ST_RX; after the last byte the input stalls during load,
// two multiply rounds, fold, a 32-step restoring modulo (one bit per cycle), result handoff.
// The handoff waits while an earlier result still waits for out_ready; the next frame's
// bytes are not accepted until this result has been handed off.
// Synchronous reset clears the frame state and sets the stored worker count to 1.
`default_nettype none
module flow_hash_worker_steering_core #(
  parameter int MAX_WORKERS = fhws_pkg::MaxWorkersDefault
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [fhws_pkg::CfgW-1:0]     worker_count,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [7:0]                    data_byte,
  input  wire                          last_byte,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [7:0]                   worker_index,
  output logic [fhws_pkg::HashW-1:0]   flow_hash,
  output logic                         recognized
);
  import fhws_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  fhws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_byte (last_byte),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  fhws_datapath #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_count    (worker_count),
    .worker_index (worker_index),
    .flow_hash    (flow_hash),
    .recognized   (recognized)
  );

endmodule
`default_nettype wire

>>> rtl/fhws_datapath.sv
// Datapath: header capture, hash mixing, serial modulo and result registers.
`default_nettype none
module fhws_datapath #(
  parameter int MAX_WORKERS = fhws_pkg::MaxWorkersDefault
) (
  input  wire                          clk,
  input  wire                          rst,
  input  fhws_pkg::cmd_t               cmd,
  input  wire [7:0]                    data_byte,
  input  wire                          last_byte,
  input  wire                          cfg_we,
  input  wire [fhws_pkg::CfgW-1:0]     cfg_count,
  output logic [7:0]                   worker_index,
  output logic [fhws_pkg::HashW-1:0]   flow_hash,
  output logic                         recognized
);
  import fhws_pkg::*;

  localparam int ClampVal = (MAX_WORKERS < (1 << CfgW) - 1) ? MAX_WORKERS : (1 << CfgW) - 1;

  logic [CfgW-1:0]  wcount;
  logic [PosW-1:0]  pos;
  kind_t            kind;
  logic [7:0]       proto;
  logic [31:0]      src_addr;
  logic [31:0]      dst_addr;
  logic [15:0]      src_port;
  logic [15:0]      dst_port;
  logic [HashW-1:0] h;
  logic             ok_r;
  logic [HashW-1:0] dq;
  logic [CfgW-1:0]  rem;

  logic [PosW-1:0]  ip;
  logic [PosW-1:0]  rel;
  logic             known;
  logic             proto_hit;
  logic             in_range;
  logic             ok;
  logic [HashW-1:0] flow_val;
  logic [CfgW-1:0]  divisor;
  logic [CfgW:0]    rem_sh;
  logic [HashW-1:0] h_fold;

  always_comb begin
    ip        = (kind == KIND_IPV4) ? IpOffIpv4 : IpOffVlan;
    rel       = pos - ip;
    known     = (kind == KIND_IPV4) || (kind == KIND_VLAN);
    proto_hit = known && (pos == ip - ProtoBack);
    in_range  = known && (pos >= ip) && (pos < ip + FlowBytes);
    ok        = known && (pos >= MinFrameLen - 6'd1);
    flow_val  = src_addr | dst_addr;
    if (proto == ProtoTcp || proto == ProtoUdp) begin
      flow_val = flow_val | {16'b0, src_port | dst_port};
    end
    if (wcount == '0) begin
      divisor = CfgW'(1);
    end else if (wcount > CfgW'(ClampVal)) begin
      divisor = CfgW'(ClampVal);
    end else begin
      divisor = wcount;
    end
    rem_sh = {rem, dq[HashW-1]};
    h_fold = h ^ (h >> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wcount   <= CfgW'(1);
      pos      <= '0;
      kind     <= KIND_NONE;
      proto    <= '0;
      src_addr <= '0;
      dst_addr <= '0;
      src_port <= '0;
      dst_port <= '0;
    end else begin
      if (cfg_we) begin
        wcount <= cfg_count;
      end
      if (cmd.capture) begin
        if (pos == TypeHiPos) begin
          if (data_byte == TypeIpv4Hi) begin
            kind <= KIND_IPV4;
          end else if (data_byte == TypeVlanHi) begin
            kind <= KIND_VLAN;
          end else begin
            kind <= KIND_NONE;
          end
        end else if (pos == TypeLoPos) begin
          if (data_byte != 8'h00) begin
            kind <= KIND_NONE;
          end
        end else if (proto_hit) begin
          proto <= data_byte;
        end else if (in_range) begin
          case (rel[3:0])
            4'd0:    src_addr[7:0]   <= src_addr[7:0]   | data_byte;
            4'd1:    src_addr[15:8]  <= src_addr[15:8]  | data_byte;
            4'd2:    src_addr[23:16] <= src_addr[23:16] | data_byte;
            4'd3:    src_addr[31:24] <= src_addr[31:24] | data_byte;
            4'd4:    dst_addr[7:0]   <= dst_addr[7:0]   | data_byte;
            4'd5:    dst_addr[15:8]  <= dst_addr[15:8]  | data_byte;
            4'd6:    dst_addr[23:16] <= dst_addr[23:16] | data_byte;
            4'd7:    dst_addr[31:24] <= dst_addr[31:24] | data_byte;
            4'd8:    src_port[7:0]   <= src_port[7:0]   | data_byte;
            4'd9:    src_port[15:8]  <= src_port[15:8]  | data_byte;
            4'd10:   dst_port[7:0]   <= dst_port[7:0]   | data_byte;
            default: dst_port[15:8]  <= dst_port[15:8]  | data_byte;
          endcase
        end
        if (!last_byte && pos != '1) begin
          pos <= pos + 6'd1;
        end
      end
      if (cmd.load) begin
        pos      <= '0;
        kind     <= KIND_NONE;
        proto    <= '0;
        src_addr <= '0;
        dst_addr <= '0;
        src_port <= '0;
        dst_port <= '0;
      end
    end
  end

  // mix32(0) is 0, so an unrecognized frame simply mixes a zero value
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h    <= ok ? flow_val : '0;
      ok_r <= ok;
    end
    if (cmd.mix1 || cmd.mix2) begin
      h <= h_fold * MixMult;
    end
    if (cmd.fold) begin
      h   <= h_fold;
      dq  <= h_fold;
      rem <= '0;
    end
    if (cmd.div_step) begin
      dq <= dq << 1;
      if (rem_sh >= {1'b0, divisor}) begin
        rem <= CfgW'(rem_sh - {1'b0, divisor});
      end else begin
        rem <= rem_sh[CfgW-1:0];
      end
    end
    if (cmd.put) begin
      worker_index <= rem[7:0];
      flow_hash    <= h;
      recognized   <= ok_r;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fhws_ctrl.sv
// Controller: sequences capture, mixing, modulo steps and result handoff.
`default_nettype none
module fhws_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  input  wire             last_byte,
  input  wire             out_ready,
  output logic            in_ready,
  output logic            out_valid,
  output fhws_pkg::cmd_t  cmd
);
  import fhws_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [DivCntW-1:0]   cnt;
  logic [DivCntW-1:0]   cnt_next;
  logic                 out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RX;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      ST_RX: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (last_byte) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_MIX1;
      end
      ST_MIX1: begin
        cmd.mix1   = 1'b1;
        state_next = ST_MIX2;
      end
      ST_MIX2: begin
        cmd.mix2   = 1'b1;
        state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == '1) begin
          state_next = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!out_valid || out_ready) begin
          cmd.put        = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_RX;
        end
      end
      default: begin
        state_next = ST_RX;
      end
    endcase
  end

endmodule
`default_nettype wire
